@@ hw/rtl/arccos_hermite_table_macros.svh @@
// assertion macros shared by the arccos table checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ARCCOS_HERMITE_TABLE_MACROS_SVH
`define ARCCOS_HERMITE_TABLE_MACROS_SVH

// same-cycle implication, masked during reset
`define ACHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define ACHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked in reset too
`define ACHT_ASSERT_NEXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/acht_pkg.sv @@
// acht_pkg: constants, stage types and knot table builders for arccos_hermite_table
// no dependencies; knot functions are evaluated at elaboration only
`default_nettype none

package acht_pkg;

  localparam int QB           = 30;
  localparam int CORDIC_ITERS = 30;
  localparam int ROOT_STEPS   = 31;

  localparam logic [31:0] PI_Q30        = 32'hC90FDAA2;
  localparam logic [30:0] PIBY2_Q30     = 31'h6487ED51;
  localparam logic [29:0] INV_SQRT2_Q30 = 30'h2D413CCD;
  localparam logic [30:0] SQRT2_Q30     = 31'h5A82799A;
  localparam longint      PIBY4_Q30     = 64'sh3243F6A9;

  typedef struct packed {
    logic neg;
    logic big;
  } acht_side_t;

  typedef struct packed {
    logic [61:0] rad;
    logic [29:0] a;
    acht_side_t  side;
  } acht_rad_t;

  typedef struct packed {
    logic [29:0] arg;
    acht_side_t  side;
  } acht_arg_t;

  // restoring long division
  function automatic longint unsigned acht_udiv(input longint unsigned num,
                                                input longint unsigned den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] n;
    q = '0;
    r = '0;
    n = num;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned acht_isqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned w;
    r = 0;
    w = v;
    b = 64'd1 << 62;
    while (b > w) b = b >> 2;
    while (b != 0) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan(2^-i) in q30 from its series
  function automatic longint acht_atan(input int i);
    longint s;
    longint term;
    int     sh;
    logic [31:0] nb;
    if (i == 0) return PIBY4_Q30;
    s = 0;
    for (int n = 0; n < 32; n++) begin
      sh = i * (2 * n + 1);
      nb = 32'(n);
      if (sh <= 62) begin
        term = longint'(acht_udiv((64'd1 << 62) >> sh, 64'(2 * n + 1)));
        s = nb[0] ? s - term : s + term;
      end
    end
    return (s + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic longint unsigned acht_knot_x(input int k, input int n);
    return acht_udiv(64'(k) * 64'(INV_SQRT2_Q30) + (64'(n - 1) >> 1), 64'(n - 1));
  endfunction

  function automatic longint unsigned acht_knot_c(input int k, input int n);
    longint unsigned xk;
    xk = acht_knot_x(k, n);
    return acht_isqrt((64'd1 << 60) - xk * xk);
  endfunction

  function automatic logic signed [31:0] acht_knot_p(input int k, input int n);
    longint cx;
    longint cy;
    longint z;
    longint nx;
    longint ny;
    cx = longint'(acht_knot_c(k, n));
    cy = longint'(acht_knot_x(k, n));
    z  = 0;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + acht_atan(i);
      end else begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - acht_atan(i);
      end
      cx = nx;
      cy = ny;
    end
    return 32'(longint'(64'(PIBY2_Q30)) - z);
  endfunction

  function automatic logic signed [31:0] acht_knot_m(input int k, input int n);
    longint unsigned den;
    longint unsigned m;
    den = acht_knot_c(k, n) * 64'(n - 1);
    m   = acht_udiv((64'(INV_SQRT2_Q30) << QB) + (den >> 1), den);
    return 32'(-longint'(m));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/arccos_hermite_table.sv @@
// arccos_hermite_table: top level, fold -> square root -> hermite interpolation
// depends on acht_pkg, acht_fold, acht_isqrt, acht_interp
//
//   channel | dir | fields (lsb first)        | handshake
//   in_     | in  | x_value, signed Q1.F      | in_tvalid / in_tready
//   out_    | out | angle, unsigned Q2.F      | out_tvalid / out_tready
//
// one transaction per cycle sustained while out_tready stays high; stages: 2 fold, 31 root, 9 interp
// the square root unit sets the depth: one result bit per stage
// reset clears the stage valid bits only
// a stalled output lets earlier stages fill any empty slots before in_tready drops
`default_nettype none

module arccos_hermite_table #(
  parameter int  FRAC_BITS    = 16,
  parameter int  TABLE_POINTS = 32,
  localparam int TDATA_W      = ((FRAC_BITS + 9) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // x_value
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata   // angle
);
  import acht_pkg::*;

  localparam int XW = FRAC_BITS + 2;

  logic          fold_valid, fold_ready;
  acht_rad_t     fold_data;
  logic          root_valid, root_ready;
  acht_arg_t     root_data;
  logic [XW-1:0] angle;

  acht_fold #(.FRAC_BITS(FRAC_BITS)) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (in_tdata[XW-1:0]),
    .out_valid (fold_valid),
    .out_ready (fold_ready),
    .out_data  (fold_data)
  );

  acht_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .in_data   (fold_data),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_data  (root_data)
  );

  acht_interp #(.FRAC_BITS(FRAC_BITS), .TABLE_POINTS(TABLE_POINTS)) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (root_valid),
    .in_ready  (root_ready),
    .in_data   (root_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_angle (angle)
  );

  assign out_tdata = TDATA_W'(angle);

endmodule

`default_nettype wire

@@ hw/rtl/acht_fold.sv @@
// acht_fold: saturation, sign fold and 1 - x^2 radicand, two register stages
// depends on acht_pkg
`default_nettype none

module acht_fold #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [FRAC_BITS+1:0]    in_x,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output acht_pkg::acht_rad_t          out_data
);
  import acht_pkg::*;

  localparam int XW = FRAC_BITS + 2;
  localparam logic [XW-1:0] ONE_X = XW'(1) << FRAC_BITS;

  logic              v0_r, v1_r;
  logic              en0, en1;
  logic [30:0]       a0_r;
  acht_side_t        side0_r;
  acht_rad_t         data1_r;

  logic              neg;
  logic [XW-1:0]     mag_full;
  logic [FRAC_BITS:0] mag;
  logic [30:0]       a_nxt;
  logic [61:0]       sq;
  acht_rad_t         data1_nxt;

  assign en1      = !v1_r || out_ready;
  assign en0      = !v0_r || en1;
  assign in_ready = en0;

  always_comb begin
    neg      = in_x[XW-1];
    mag_full = neg ? (~in_x + XW'(1)) : in_x;
    mag      = (mag_full > ONE_X) ? ONE_X[FRAC_BITS:0] : mag_full[FRAC_BITS:0];
    a_nxt    = 31'(mag) << (QB - FRAC_BITS);
  end

  always_comb begin
    sq                  = 62'(a0_r) * 62'(a0_r);
    data1_nxt.rad       = (62'(1) << 60) - sq;
    data1_nxt.a         = a0_r[29:0];
    data1_nxt.side      = side0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_valid;
      if (en1) v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      a0_r          <= a_nxt;
      side0_r.neg   <= neg;
      side0_r.big   <= a_nxt > 31'(INV_SQRT2_Q30);
    end
    if (en1) data1_r <= data1_nxt;
  end

  assign out_valid = v1_r;
  assign out_data  = data1_r;

endmodule

`default_nettype wire

@@ hw/rtl/acht_isqrt.sv @@
// acht_isqrt: pipelined floor square root, one result bit per register stage
// depends on acht_pkg; picks the folded argument at its output
`default_nettype none

module acht_isqrt (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  acht_pkg::acht_rad_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output acht_pkg::acht_arg_t out_data
);
  import acht_pkg::*;

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
    logic [29:0] a;
    acht_side_t  side;
  } step_t;

  step_t st_r   [ROOT_STEPS];
  step_t prev_w [ROOT_STEPS];
  logic  v_r    [ROOT_STEPS];
  logic  vin_w  [ROOT_STEPS];
  logic  en     [ROOT_STEPS+1];

  assign en[ROOT_STEPS] = out_ready;
  assign in_ready       = en[0];

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_step
    step_t       st_nxt;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      always_comb begin
        prev_w[i].rem  = '0;
        prev_w[i].root = '0;
        prev_w[i].rad  = in_data.rad;
        prev_w[i].a    = in_data.a;
        prev_w[i].side = in_data.side;
      end
      assign vin_w[i] = in_valid;
    end else begin : g_rest
      assign prev_w[i] = st_r[i-1];
      assign vin_w[i]  = v_r[i-1];
    end

    assign en[i] = !v_r[i] || en[i+1];

    always_comb begin
      rem_sh      = {prev_w[i].rem[31:0], prev_w[i].rad[61:60]};
      trial       = {1'b0, prev_w[i].root, 2'b01};
      ge          = rem_sh >= trial;
      st_nxt.rem  = ge ? rem_sh - trial : rem_sh;
      st_nxt.root = {prev_w[i].root[29:0], ge};
      st_nxt.rad  = prev_w[i].rad << 2;
      st_nxt.a    = prev_w[i].a;
      st_nxt.side = prev_w[i].side;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else if (en[i]) v_r[i] <= vin_w[i];
    end

    always_ff @(posedge clk) begin
      if (en[i]) st_r[i] <= st_nxt;
    end
  end

  assign out_valid     = v_r[ROOT_STEPS-1];
  assign out_data.arg  = st_r[ROOT_STEPS-1].side.big ? st_r[ROOT_STEPS-1].root[29:0]
                                                     : st_r[ROOT_STEPS-1].a;
  assign out_data.side = st_r[ROOT_STEPS-1].side;

endmodule

`default_nettype wire

@@ hw/rtl/acht_interp.sv @@
// acht_interp: knot position, cubic hermite sum over the knot table and angle unfold
// depends on acht_pkg (constants, knot builders); nine register stages
`default_nettype none

module acht_interp #(
  parameter int FRAC_BITS    = 16,
  parameter int TABLE_POINTS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  acht_pkg::acht_arg_t       in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [FRAC_BITS+1:0]      out_angle
);
  import acht_pkg::*;

  localparam int XW = FRAC_BITS + 2;
  localparam int IW = $clog2(TABLE_POINTS);
  localparam int PW = 31 + IW;
  localparam int NS = 9;
  localparam logic [IW-1:0] LAST_IV  = IW'(TABLE_POINTS - 1);
  localparam logic [IW-1:0] CLAMP_IX = IW'(TABLE_POINTS - 2);
  localparam logic signed [33:0] ONE_S = 34'sd1 <<< QB;

  // knot values and scaled slopes
  logic signed [31:0] p_tab [TABLE_POINTS];
  logic signed [31:0] m_tab [TABLE_POINTS];
  for (genvar k = 0; k < TABLE_POINTS; k++) begin : g_knot
    localparam logic signed [31:0] KP = acht_knot_p(k, TABLE_POINTS);
    localparam logic signed [31:0] KM = acht_knot_m(k, TABLE_POINTS);
    assign p_tab[k] = KP;
    assign m_tab[k] = KM;
  end

  logic       v_r  [NS];
  logic       en   [NS+1];
  acht_side_t sd_r [NS];

  assign en[NS]   = out_ready;
  assign in_ready = en[0];
  for (genvar s = 0; s < NS; s++) begin : g_ctl
    assign en[s] = !v_r[s] || en[s+1];
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[s] <= 1'b0;
      else if (en[s]) v_r[s] <= (s == 0) ? in_valid : v_r[(s == 0) ? 0 : s-1];
    end
    always_ff @(posedge clk) begin
      if (en[s]) sd_r[s] <= (s == 0) ? in_data.side : sd_r[(s == 0) ? 0 : s-1];
    end
  end

  // stage 0: scale to [0, 1]
  logic [60:0] u_prod;
  logic [30:0] u_r;
  assign u_prod = 61'(in_data.arg) * 61'(SQRT2_Q30);
  always_ff @(posedge clk) if (en[0]) u_r <= u_prod[60:30];

  // stage 1: knot index and fraction, end of table clamp
  logic [PW-1:0] pos;
  logic [IW:0]   idx_full;
  logic [IW-1:0] idx_nxt, idx1_r;
  logic [30:0]   t_nxt, t1_r;
  always_comb begin
    pos      = PW'(u_r) * PW'(LAST_IV);
    idx_full = pos[PW-1:30];
    if (idx_full >= (IW+1)'(TABLE_POINTS - 1)) begin
      idx_nxt = CLAMP_IX;
      t_nxt   = 31'(1) << QB;
    end else begin
      idx_nxt = idx_full[IW-1:0];
      t_nxt   = {1'b0, pos[29:0]};
    end
  end
  always_ff @(posedge clk) begin
    if (en[1]) begin
      idx1_r <= idx_nxt;
      t1_r   <= t_nxt;
    end
  end

  // stage 2: t^2
  logic [61:0]   sq_prod;
  logic [IW-1:0] idx2_r;
  logic [30:0]   t2_r, sq2_r;
  assign sq_prod = 62'(t1_r) * 62'(t1_r);
  always_ff @(posedge clk) begin
    if (en[2]) begin
      idx2_r <= idx1_r;
      t2_r   <= t1_r;
      sq2_r  <= sq_prod[60:30];
    end
  end

  // stage 3: t^3 and table reads
  logic [61:0]        cu_prod;
  logic [IW-1:0]      idx_hi;
  logic [30:0]        t3_r, sq3_r, cu3_r;
  logic signed [31:0] p0_r, m0_r, p1_r, m1_r;
  assign cu_prod = 62'(sq2_r) * 62'(t2_r);
  assign idx_hi  = idx2_r + IW'(1);
  always_ff @(posedge clk) begin
    if (en[3]) begin
      t3_r  <= t2_r;
      sq3_r <= sq2_r;
      cu3_r <= cu_prod[60:30];
      p0_r  <= p_tab[idx2_r];
      m0_r  <= m_tab[idx2_r];
      p1_r  <= p_tab[idx_hi];
      m1_r  <= m_tab[idx_hi];
    end
  end

  // stage 4: hermite basis
  logic signed [33:0] st, ssq, scu;
  logic signed [33:0] h00_nxt, h10_nxt, h01_nxt, h11_nxt;
  logic signed [33:0] h00_r, h10_r, h01_r, h11_r;
  logic signed [31:0] p0_4_r, m0_4_r, p1_4_r, m1_4_r;
  always_comb begin
    st      = $signed({3'b000, t3_r});
    ssq     = $signed({3'b000, sq3_r});
    scu     = $signed({3'b000, cu3_r});
    h00_nxt = (scu <<< 1) - (ssq + (ssq <<< 1)) + ONE_S;
    h10_nxt = scu - (ssq <<< 1) + st;
    h01_nxt = (ssq + (ssq <<< 1)) - (scu <<< 1);
    h11_nxt = scu - ssq;
  end
  always_ff @(posedge clk) begin
    if (en[4]) begin
      h00_r  <= h00_nxt;
      h10_r  <= h10_nxt;
      h01_r  <= h01_nxt;
      h11_r  <= h11_nxt;
      p0_4_r <= p0_r;
      m0_4_r <= m0_r;
      p1_4_r <= p1_r;
      m1_4_r <= m1_r;
    end
  end

  // stage 5: four partial products
  logic signed [65:0] pr0_r, pr1_r, pr2_r, pr3_r;
  logic signed [65:0] pr0_nxt, pr1_nxt, pr2_nxt, pr3_nxt;
  always_comb begin
    pr0_nxt = h00_r * p0_4_r;
    pr1_nxt = h10_r * m0_4_r;
    pr2_nxt = h01_r * p1_4_r;
    pr3_nxt = h11_r * m1_4_r;
  end
  always_ff @(posedge clk) begin
    if (en[5]) begin
      pr0_r <= pr0_nxt;
      pr1_r <= pr1_nxt;
      pr2_r <= pr2_nxt;
      pr3_r <= pr3_nxt;
    end
  end

  // stage 6: q60 sum
  logic signed [67:0] acc_r, acc_nxt;
  assign acc_nxt = 68'(pr0_r) + 68'(pr1_r) + 68'(pr2_r) + 68'(pr3_r);
  always_ff @(posedge clk) if (en[6]) acc_r <= acc_nxt;

  // stage 7: clamp at zero, round to q30, saturate at pi/2
  logic [66:0] acc_pos;
  logic [66:0] acc_rnd;
  logic [36:0] y_full;
  logic [30:0] y7_r, y7_nxt;
  always_comb begin
    acc_pos = acc_r[67] ? '0 : acc_r[66:0];
    acc_rnd = acc_pos + (67'(1) << (QB - 1));
    y_full  = acc_rnd[66:30];
    y7_nxt  = (y_full > 37'(PIBY2_Q30)) ? PIBY2_Q30 : y_full[30:0];
  end
  always_ff @(posedge clk) if (en[7]) y7_r <= y7_nxt;

  // stage 8: undo folds, round to output format
  logic [30:0] y_big;
  logic [31:0] y_neg;
  logic [34:0] y_rnd;
  logic [XW-1:0] angle_r, angle_nxt;
  always_comb begin
    y_big     = sd_r[7].big ? PIBY2_Q30 - y7_r : y7_r;
    y_neg     = sd_r[7].neg ? PI_Q30 - {1'b0, y_big} : {1'b0, y_big};
    y_rnd     = ({2'b00, y_neg, 1'b0} + (35'(1) << (QB - FRAC_BITS))) >> (QB + 1 - FRAC_BITS);
    angle_nxt = y_rnd[XW-1:0];
  end
  always_ff @(posedge clk) if (en[8]) angle_r <= angle_nxt;

  assign out_valid = v_r[NS-1];
  assign out_angle = angle_r;

endmodule

`default_nettype wire

@@ hw/rtl/acht_checker.sv @@
// acht_checker: port-level assertions for arccos_hermite_table, bound to the top
// depends on arccos_hermite_table_macros.svh
`default_nettype none
`include "arccos_hermite_table_macros.svh"

module acht_checker #(
  parameter int TDATA_W = 24
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic [TDATA_W-1:0] in_tdata,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `ACHT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed under stall")

  // empty output register means the pipe can take a transaction
  `ACHT_ASSERT_NOW(a_ready_when_drained, !out_tvalid, in_tready, "input blocked with empty output")

  // reset empties the pipe
  `ACHT_ASSERT_NEXT_ALL(a_reset_empty, !rst_n, !out_tvalid, "result valid right after reset")

  // an accepted transaction carries no unknown bits
  `ACHT_ASSERT_NOW(a_in_known, in_tvalid && in_tready, !$isunknown(in_tdata), "unknown input accepted")

endmodule

bind arccos_hermite_table acht_checker #(.TDATA_W($bits(out_tdata))) u_acht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ test/arccos_checker.sv @@
// arccos_checker: watches both stream channels of arccos_hermite_table, predicts each angle
// from its own knot table and compares it with what comes out; no package dependency
`timescale 1ns / 1ps

module arccos_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // x_value
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // angle
  output int          fail_count,
  output int          pending
);

  localparam int     KNOTS   = 32;
  localparam int     FB      = 16;
  localparam int     QF      = 30;
  localparam longint ONE_Q   = 64'sd1 << QF;
  localparam longint PI_Q    = 64'shC90FDAA2;
  localparam longint HALF_PI = 64'sh6487ED51;
  localparam longint QTR_PI  = 64'sh3243F6A9;
  localparam longint INV_RT2 = 64'sh2D413CCD;
  localparam longint RT2     = 64'sh5A82799A;

  longint    knot_val[KNOTS];
  longint    knot_slope[KNOTS];
  bit [17:0] angle_q[$];

  function automatic longint root_floor(input longint unsigned v);
    longint unsigned r, b, w;
    r = 0;
    w = v;
    b = 64'd1 << 62;
    while (b > w) b = b >> 2;
    while (b != 0) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // knot values by cordic arcsine, slopes scaled by the knot spacing
  function automatic void fill_knots();
    longint atn[30];
    longint s, term, xk, ck, cx, cy, z, nx, ny, den;
    int     sh;
    atn[0] = QTR_PI;
    for (int i = 1; i < 30; i++) begin
      s = 0;
      for (int n = 0; n < 40; n++) begin
        sh = i * (2 * n + 1);
        if (sh > 62) break;
        term = ((64'sd1 <<< 62) >>> sh) / (2 * n + 1);
        s = (n % 2 == 1) ? s - term : s + term;
      end
      atn[i] = (s + (64'sd1 <<< 31)) >>> 32;
    end
    for (int k = 0; k < KNOTS; k++) begin
      xk = (k * INV_RT2 + (KNOTS - 1) / 2) / (KNOTS - 1);
      ck = root_floor((64'd1 << 60) - xk * xk);
      cx = ck;
      cy = xk;
      z  = 0;
      den = ck * (KNOTS - 1);
      for (int i = 0; i < 30; i++) begin
        if (cy > 0) begin
          nx = cx + (cy >>> i);
          ny = cy - (cx >>> i);
          z  = z + atn[i];
        end else begin
          nx = cx - (cy >>> i);
          ny = cy + (cx >>> i);
          z  = z - atn[i];
        end
        cx = nx;
        cy = ny;
      end
      knot_val[k]   = HALF_PI - z;
      knot_slope[k] = -(((INV_RT2 <<< QF) + den / 2) / den);
    end
  endfunction

  function automatic bit [17:0] arccos_angle(input bit [17:0] x);
    bit     neg, big;
    longint mag, a, pos, idx, t, t2, t3, acc, y;
    neg = x[17];
    mag = neg ? (64'sd1 <<< 18) - longint'(x) : longint'(x);
    if (mag > (64'sd1 <<< FB)) mag = 64'sd1 <<< FB;
    a = mag <<< (QF - FB);
    big = a > INV_RT2;
    if (big) a = root_floor((64'd1 << 60) - a * a);
    pos = ((a * RT2) >>> QF) * (KNOTS - 1);
    idx = pos >>> QF;
    t   = pos & (ONE_Q - 1);
    // end of table: stay on the last interval at its far end
    if (idx >= KNOTS - 1) begin
      idx = KNOTS - 2;
      t   = ONE_Q;
    end
    t2 = (t * t) >>> QF;
    t3 = (t2 * t) >>> QF;
    acc = (2 * t3 - 3 * t2 + ONE_Q) * knot_val[idx] + (t3 - 2 * t2 + t) * knot_slope[idx]
        + (3 * t2 - 2 * t3) * knot_val[idx + 1] + (t3 - t2) * knot_slope[idx + 1];
    if (acc < 0) acc = 0;
    y = (acc + (64'sd1 <<< (QF - 1))) >>> QF;
    if (y > HALF_PI) y = HALF_PI;
    if (big) y = HALF_PI - y;
    if (neg) y = PI_Q - y;
    return 18'((y + (64'sd1 <<< (QF - FB - 1))) >>> (QF - FB));
  endfunction

  initial begin
    fail_count = 0;
    fill_knots();
  end

  assign pending = angle_q.size();

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) angle_q.push_back(arccos_angle(in_tdata[17:0]));
      if (out_tvalid && out_tready) begin
        if (angle_q.size() == 0) begin
          $display("%0t: unexpected transaction, angle %0d", $time, out_tdata[17:0]);
          fail_count <= fail_count + 1;
        end else if (out_tdata[17:0] !== angle_q[0]) begin
          $display("%0t: angle mismatch, expected %0d, actual %0d",
                   $time, angle_q[0], out_tdata[17:0]);
          fail_count <= fail_count + 1;
          void'(angle_q.pop_front());
        end else begin
          void'(angle_q.pop_front());
        end
      end
    end
  end

endmodule

@@ test/testbench.sv @@
// testbench: drives x values into arccos_hermite_table with random idling and back-pressure
// depends on the block and on arccos_checker, which predicts and compares
`timescale 1ns / 1ps

module testbench;

  localparam int WATCH_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 1430;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  int          fail_count;
  int          pending;
  int          sent;
  bit          hold_req;
  bit          no_idle;

  arccos_hermite_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  arccos_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one x per transaction, random idle cycles after it
  task automatic send_x(input logic [17:0] x);
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, x};
    do @(posedge clk); while (!in_tready);
    sent++;
    if (!no_idle) begin
      while ($urandom_range(99) < 24) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  // watchdog: cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [17:0] corner[$];
    logic [17:0] x;
    corner = '{18'h10000, 18'h30000, 18'h00000, 18'h00001, 18'h3FFFF, 18'h0B504,
               18'h0B505, 18'h34AFC, 18'h34AFB, 18'h0FFFF, 18'h30001, 18'h10001,
               18'h2FFFF, 18'h1FFFF, 18'h20000, 18'h08000, 18'h38000, 18'h0B4FF,
               18'h0B50A, 18'h00400, 18'h3FC00, 18'h0F000, 18'h31000, 18'h15555};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    sent      = 0;
    hold_req  = 1'b0;
    no_idle   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (corner[i]) send_x(corner[i]);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_idle = (n >= 500 && n < 700);
      if (n == 300) hold_req = 1'b1;
      if (n == 900) begin
        // wait for the pipeline to drain before going on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
      case ($urandom_range(9))
        0, 1: x = 18'($urandom);
        2: x = 18'($urandom_range(46400, 46280));
        3: x = 18'(-$urandom_range(46400, 46280));
        4: x = $urandom_range(1) ? 18'($urandom_range(65536, 65000))
                                  : 18'(-$urandom_range(65536, 65000));
        default: x = 18'($urandom_range(131072)) - 18'd65536;
      endcase
      send_x(x);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ arccos_hermite_table.f @@
+incdir+hw/rtl
hw/rtl/acht_pkg.sv
hw/rtl/acht_fold.sv
hw/rtl/acht_isqrt.sv
hw/rtl/acht_interp.sv
hw/rtl/arccos_hermite_table.sv
hw/rtl/acht_checker.sv
test/arccos_checker.sv
test/testbench.sv
